>>> rtl/ilx_pkg.sv
// ----------------------------------------------------------------------------
// ilx_pkg
// Shared types and constants for the integer literal lexer: lexer states,
// token kind codes, character codes and the hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ilx_pkg;

  // Lexer states. Codes above ST_OCTL carry no meaning.
  typedef enum logic [3:0] {
    ST_WS   = 4'd0,
    ST_ZERO = 4'd1,
    ST_OCT  = 4'd2,
    ST_HEX  = 4'd3,
    ST_DEC  = 4'd4,
    ST_ILL  = 4'd5,
    ST_PFX  = 4'd6,
    ST_DECL = 4'd7,
    ST_HEXL = 4'd8,
    ST_OCTL = 4'd9
  } lex_state_t;

  // Token kind codes as shown on the result port.
  typedef enum logic [1:0] {
    KIND_DEC     = 2'd0,
    KIND_OCT     = 2'd1,
    KIND_HEX     = 2'd2,
    KIND_ILLEGAL = 2'd3
  } token_kind_t;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_SEVEN   = 8'h37;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_L = 8'h4C;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  // Hex digit value in the low four bits; bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd16;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      res = {1'b0, 4'(c - CHAR_ZERO)};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      res = {1'b0, 4'(c - CHAR_LOWER_A + 8'd10)};
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      res = {1'b0, 4'(c - CHAR_UPPER_A + 8'd10)};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/integer_literal_lexer.sv
// ----------------------------------------------------------------------------
// integer_literal_lexer
// Character-stream lexer that classifies whitespace-separated C integer
// literals (decimal, octal, hex, optional L suffix) and reports each token.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+--------------------------
//  char     | in        | char_valid / char_stall   | char_byte
//  token    | out       | token_valid / token_stall | token_index, token_kind,
//           |           |                           | is_long, literal_value
//
// One character transaction is taken in every clock cycle when the result side
// keeps up. A character is held in an input register, where the state update
// and the constant multiply-accumulate of the value are done; a token result
// is loaded into the output register when its terminating whitespace leaves
// the input register.
// Reset (rst, synchronous, active high) returns the lexer to the whitespace
// state with a zero value and zero token count, and empties both registers.
// When the output register holds a result that is stalled, characters that do
// not end a token are still processed; only a token-ending whitespace waits,
// and then char_stall is raised once the input register is occupied.
//
// ----------------------------------------------------------------------------
`default_nettype none

module integer_literal_lexer #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  output logic             char_stall,
  input  wire logic [7:0]  char_byte,
  output logic             token_valid,
  input  wire logic        token_stall,
  output logic [31:0]      token_index,
  output logic [1:0]       token_kind,
  output logic             is_long,
  output logic [31:0]      literal_value
);

  // Input register: the character waiting to be lexed.
  logic       char_full;
  logic [7:0] char_reg;

  // Lexer state held between characters.
  ilx_pkg::lex_state_t    lex_state;
  ilx_pkg::lex_state_t    lex_state_next;
  logic [VALUE_WIDTH-1:0] token_value;
  logic [VALUE_WIDTH-1:0] token_value_next;
  logic [31:0]            token_count;

  // Decoded character.
  logic       is_ws;
  logic       is_dec_digit;
  logic       is_oct_digit;
  logic [4:0] hex_val;
  logic       is_hex_digit;

  // Result of the current character.
  logic                 emit;
  ilx_pkg::token_kind_t emit_kind;
  logic                 emit_long;
  logic [63:0]          emit_value_wide;
  logic                 out_free;
  logic                 consume;

  assign is_ws        = (char_reg == ilx_pkg::CHAR_SPACE) ||
                        (char_reg == ilx_pkg::CHAR_NEWLINE);
  assign is_dec_digit = (char_reg >= ilx_pkg::CHAR_ZERO) &&
                        (char_reg <= ilx_pkg::CHAR_NINE);
  assign is_oct_digit = (char_reg >= ilx_pkg::CHAR_ZERO) &&
                        (char_reg <= ilx_pkg::CHAR_SEVEN);
  assign hex_val      = ilx_pkg::hex_digit(char_reg);
  assign is_hex_digit = !hex_val[4];

  // A token ends on the first whitespace after it; whitespace between tokens
  // produces nothing.
  assign emit     = char_full && is_ws && (lex_state != ilx_pkg::ST_WS);
  // The output register can take a new result if it is empty or being drained.
  assign out_free = !token_valid || !token_stall;
  // The held character is processed unless it must wait for the output.
  assign consume    = char_full && (!emit || out_free);
  assign char_stall = char_full && !consume;

  // Next-state logic of the lexer.
  always_comb begin
    lex_state_next = lex_state;
    if (is_ws) begin
      lex_state_next = ilx_pkg::ST_WS;
    end else begin
      case (lex_state)
        ilx_pkg::ST_WS: begin
          if (char_reg == ilx_pkg::CHAR_ZERO) begin
            lex_state_next = ilx_pkg::ST_ZERO;
          end else if (is_dec_digit) begin
            lex_state_next = ilx_pkg::ST_DEC;
          end else begin
            lex_state_next = ilx_pkg::ST_ILL;
          end
        end
        ilx_pkg::ST_ZERO: begin
          if (is_oct_digit) begin
            lex_state_next = ilx_pkg::ST_OCT;
          end else if (char_reg == ilx_pkg::CHAR_LOWER_X ||
                       char_reg == ilx_pkg::CHAR_UPPER_X) begin
            lex_state_next = ilx_pkg::ST_PFX;
          end else begin
            lex_state_next = ilx_pkg::ST_ILL;
          end
        end
        ilx_pkg::ST_OCT: begin
          if (is_oct_digit) begin
            lex_state_next = ilx_pkg::ST_OCT;
          end else if (char_reg == ilx_pkg::CHAR_UPPER_L) begin
            lex_state_next = ilx_pkg::ST_OCTL;
          end else begin
            lex_state_next = ilx_pkg::ST_ILL;
          end
        end
        ilx_pkg::ST_PFX: begin
          if (is_hex_digit) begin
            lex_state_next = ilx_pkg::ST_HEX;
          end else begin
            lex_state_next = ilx_pkg::ST_ILL;
          end
        end
        ilx_pkg::ST_HEX: begin
          if (is_hex_digit) begin
            lex_state_next = ilx_pkg::ST_HEX;
          end else if (char_reg == ilx_pkg::CHAR_UPPER_L) begin
            lex_state_next = ilx_pkg::ST_HEXL;
          end else begin
            lex_state_next = ilx_pkg::ST_ILL;
          end
        end
        ilx_pkg::ST_DEC: begin
          if (is_dec_digit) begin
            lex_state_next = ilx_pkg::ST_DEC;
          end else if (char_reg == ilx_pkg::CHAR_UPPER_L) begin
            lex_state_next = ilx_pkg::ST_DECL;
          end else begin
            lex_state_next = ilx_pkg::ST_ILL;
          end
        end
        default: begin
          // Illegal stays illegal, and anything after a suffix breaks it.
          lex_state_next = ilx_pkg::ST_ILL;
        end
      endcase
    end
  end

  // Output logic: value accumulation and the token report.
  always_comb begin
    token_value_next = token_value;
    emit_kind        = ilx_pkg::KIND_ILLEGAL;
    emit_long        = 1'b0;

    case (lex_state)
      ilx_pkg::ST_DEC, ilx_pkg::ST_ZERO: begin
        emit_kind = ilx_pkg::KIND_DEC;
      end
      ilx_pkg::ST_DECL: begin
        emit_kind = ilx_pkg::KIND_DEC;
        emit_long = 1'b1;
      end
      ilx_pkg::ST_OCT: begin
        emit_kind = ilx_pkg::KIND_OCT;
      end
      ilx_pkg::ST_OCTL: begin
        emit_kind = ilx_pkg::KIND_OCT;
        emit_long = 1'b1;
      end
      ilx_pkg::ST_HEX: begin
        emit_kind = ilx_pkg::KIND_HEX;
      end
      ilx_pkg::ST_HEXL: begin
        emit_kind = ilx_pkg::KIND_HEX;
        emit_long = 1'b1;
      end
      default: begin
        emit_kind = ilx_pkg::KIND_ILLEGAL;
      end
    endcase

    if (is_ws) begin
      token_value_next = '0;
    end else begin
      case (lex_state_next)
        ilx_pkg::ST_DEC: begin
          token_value_next = (token_value << 3) + (token_value << 1) +
                             VALUE_WIDTH'(hex_val[3:0]);
        end
        ilx_pkg::ST_OCT: begin
          token_value_next = (token_value << 3) + VALUE_WIDTH'(hex_val[3:0]);
        end
        ilx_pkg::ST_HEX: begin
          token_value_next = (token_value << 4) + VALUE_WIDTH'(hex_val[3:0]);
        end
        ilx_pkg::ST_DECL, ilx_pkg::ST_OCTL, ilx_pkg::ST_HEXL: begin
          token_value_next = token_value;
        end
        default: begin
          token_value_next = '0;
        end
      endcase
    end
  end

  // Illegal tokens report a zero value; the value is shown in 32 bits.
  assign emit_value_wide = (emit_kind == ilx_pkg::KIND_ILLEGAL) ? 64'd0 :
                           64'(token_value);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_full <= 1'b0;
    end else if (!char_stall) begin
      char_full <= char_valid;
    end
    if (!char_stall && char_valid) begin
      char_reg <= char_byte;
    end
  end

  // Lexer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state   <= ilx_pkg::ST_WS;
      token_value <= '0;
      token_count <= '0;
    end else if (consume) begin
      lex_state   <= lex_state_next;
      token_value <= token_value_next;
      if (emit) begin
        token_count <= token_count + 32'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (emit && consume) begin
      token_valid <= 1'b1;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
    if (emit && consume) begin
      token_index   <= token_count + 32'd1;
      token_kind    <= emit_kind;
      is_long       <= emit_long;
      literal_value <= emit_value_wide[31:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ilx_checker.sv
// ----------------------------------------------------------------------------
// ilx_port_checker
// Port-level checks for the integer literal lexer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ilx_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        char_valid,
  input wire logic        char_stall,
  input wire logic        token_valid,
  input wire logic        token_stall,
  input wire logic [31:0] token_index,
  input wire logic [1:0]  token_kind,
  input wire logic        is_long,
  input wire logic [31:0] literal_value
);

  logic [31:0] last_index;

  // Index of the last result transaction taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= '0;
    end else if (token_valid && !token_stall) begin
      last_index <= token_index;
    end
  end

  // Each reported token follows the previous one in number.
  assert property (@(posedge clk) disable iff (rst)
    token_valid |-> token_index == last_index + 32'd1)
    else $error("token index out of sequence");

  // Illegal tokens carry neither value nor suffix.
  assert property (@(posedge clk) disable iff (rst)
    token_valid && token_kind == ilx_pkg::KIND_ILLEGAL |->
      literal_value == 32'd0 && !is_long)
    else $error("illegal token with value or suffix");

  // A stalled result stays and holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=>
      token_valid && $stable(token_index) && $stable(token_kind) &&
      $stable(is_long) && $stable(literal_value))
    else $error("stalled result changed");

  // Leaving reset, no result is shown and characters are taken.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !token_valid && !(char_valid && char_stall))
    else $error("lexer not empty after reset");

endmodule

bind integer_literal_lexer ilx_port_checker u_ilx_checker (.*);

`default_nettype wire

>>> sim/ilx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilx_checker
// Watches both channels of the integer literal lexer, predicts every token
// result from the accepted characters and compares the results as they leave.
// ----------------------------------------------------------------------------
module ilx_checker
  import ilx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  input  wire logic        char_stall,
  input  wire logic [7:0]  char_byte,
  input  wire logic        token_valid,
  input  wire logic        token_stall,
  input  wire logic [31:0] token_index,
  input  wire logic [1:0]  token_kind,
  input  wire logic        is_long,
  input  wire logic [31:0] literal_value,
  output int               fail_count,
  output int               pending_tokens,
  output int               tokens_checked,
  output int               illegal_seen,
  output int               long_seen
);

  typedef struct {
    logic [31:0] index;
    token_kind_t kind;
    logic        long_flag;
    logic [31:0] value;
  } token_rec_t;

  // Predicted lexer state.
  lex_state_t  lex_st;
  logic [31:0] acc_value;
  logic [31:0] token_total;

  token_rec_t  due_tokens[$];
  token_rec_t  next_tok;
  token_rec_t  want;
  int          errors;
  int          checked;
  int          n_illegal;
  int          n_long;

  // Digit weight in base 16, or -1 when the byte is no hex digit.
  function automatic int digit_weight(input logic [7:0] c);
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) return int'(c - CHAR_ZERO);
    if (c inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) return int'(c - CHAR_LOWER_A) + 10;
    if (c inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) return int'(c - CHAR_UPPER_A) + 10;
    return -1;
  endfunction

  // Advances the predicted lexer by one character; returns 1 with the
  // finished token when the character closes one.
  function automatic bit classify_char(input logic [7:0] c, output token_rec_t tok);
    int         w;
    lex_state_t nxt;
    w = digit_weight(c);
    tok.index = '0;
    tok.kind = KIND_DEC;
    tok.long_flag = 1'b0;
    tok.value = '0;
    if (c == CHAR_SPACE || c == CHAR_NEWLINE) begin
      if (lex_st == ST_WS) return 1'b0;
      case (lex_st)
        ST_DEC, ST_ZERO: tok.kind = KIND_DEC;
        ST_DECL: begin
          tok.kind = KIND_DEC;
          tok.long_flag = 1'b1;
        end
        ST_OCT: tok.kind = KIND_OCT;
        ST_OCTL: begin
          tok.kind = KIND_OCT;
          tok.long_flag = 1'b1;
        end
        ST_HEX: tok.kind = KIND_HEX;
        ST_HEXL: begin
          tok.kind = KIND_HEX;
          tok.long_flag = 1'b1;
        end
        default: tok.kind = KIND_ILLEGAL;
      endcase
      tok.value = (tok.kind == KIND_ILLEGAL) ? 32'd0 : acc_value;
      token_total = token_total + 32'd1;
      tok.index = token_total;
      lex_st = ST_WS;
      acc_value = '0;
      return 1'b1;
    end
    case (lex_st)
      ST_WS: begin
        if (c == CHAR_ZERO) nxt = ST_ZERO;
        else if (c inside {[CHAR_ZERO:CHAR_NINE]}) nxt = ST_DEC;
        else nxt = ST_ILL;
      end
      ST_ZERO: begin
        if (c inside {[CHAR_ZERO:CHAR_SEVEN]}) nxt = ST_OCT;
        else if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) nxt = ST_PFX;
        else nxt = ST_ILL;
      end
      ST_OCT: begin
        if (c inside {[CHAR_ZERO:CHAR_SEVEN]}) nxt = ST_OCT;
        else if (c == CHAR_UPPER_L) nxt = ST_OCTL;
        else nxt = ST_ILL;
      end
      ST_PFX: nxt = (w >= 0) ? ST_HEX : ST_ILL;
      ST_HEX: begin
        if (w >= 0) nxt = ST_HEX;
        else if (c == CHAR_UPPER_L) nxt = ST_HEXL;
        else nxt = ST_ILL;
      end
      ST_DEC: begin
        if (c inside {[CHAR_ZERO:CHAR_NINE]}) nxt = ST_DEC;
        else if (c == CHAR_UPPER_L) nxt = ST_DECL;
        else nxt = ST_ILL;
      end
      default: nxt = ST_ILL;
    endcase
    case (nxt)
      ST_DECL, ST_OCTL, ST_HEXL: ;
      ST_DEC: acc_value = acc_value * 32'd10 + 32'(w);
      ST_OCT: acc_value = acc_value * 32'd8 + 32'(w);
      ST_HEX: acc_value = acc_value * 32'd16 + 32'(w);
      default: acc_value = '0;
    endcase
    lex_st = nxt;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      lex_st = ST_WS;
      acc_value = '0;
      token_total = '0;
      due_tokens.delete();
    end else begin
      // Results are compared before the new character is predicted: a result
      // can never stem from a character accepted at the same edge.
      if (token_valid && !token_stall) begin
        checked++;
        if (token_kind == KIND_ILLEGAL) n_illegal++;
        if (is_long) n_long++;
        if (due_tokens.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: token result with none due: index %0d kind %0d long %0b value %h",
                     $time, token_index, token_kind, is_long, literal_value);
          end
        end else begin
          want = due_tokens.pop_front();
          if (token_index !== want.index || token_kind !== want.kind ||
              is_long !== want.long_flag || literal_value !== want.value) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: token mismatch: expected index %0d kind %0d long %0b value %h",
                       $time, want.index, want.kind, want.long_flag, want.value);
              $display("%0t:                   got index %0d kind %0d long %0b value %h",
                       $time, token_index, token_kind, is_long, literal_value);
            end
          end
        end
      end
      if (char_valid && !char_stall) begin
        if (classify_char(char_byte, next_tok)) due_tokens.push_back(next_tok);
      end
    end
    fail_count     <= errors;
    pending_tokens <= due_tokens.size();
    tokens_checked <= checked;
    illegal_seen   <= n_illegal;
    long_seen      <= n_long;
  end

endmodule

>>> sim/tb_integer_literal_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_literal_lexer
// Streams characters into the integer literal lexer: a short directed text
// with the corner cases of the literal grammar, then random tokens, broken
// tokens and noise, with random idling on both channels and one long hold-off
// on the result side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_integer_literal_lexer;
  import ilx_pkg::*;

  // The long hold-off starts once this many characters have gone in.
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 200;
  // Least size of the character stream; the last stretch of it runs without idling.
  localparam int SCRIPT_LEN   = 1750;
  localparam int QUIET_TAIL   = 250;

  logic        clk;
  logic        rst;
  logic        char_valid;
  logic        char_stall;
  logic [7:0]  char_byte;
  logic        token_valid;
  logic        token_stall;
  logic [31:0] token_index;
  logic [1:0]  token_kind;
  logic        is_long;
  logic [31:0] literal_value;

  int fail_count;
  int pending_tokens;
  int tokens_checked;
  int illegal_seen;
  int long_seen;

  // The whole character stream is built before it is sent.
  logic [7:0] script[$];
  int         sent_count;
  bit         last_part;
  bit         hold_active;
  bit         hold_done;

  integer_literal_lexer u_dut (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_byte     (char_byte),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .token_index   (token_index),
    .token_kind    (token_kind),
    .is_long       (is_long),
    .literal_value (literal_value)
  );

  ilx_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .char_byte      (char_byte),
    .token_valid    (token_valid),
    .token_stall    (token_stall),
    .token_index    (token_index),
    .token_kind     (token_kind),
    .is_long        (is_long),
    .literal_value  (literal_value),
    .fail_count     (fail_count),
    .pending_tokens (pending_tokens),
    .tokens_checked (tokens_checked),
    .illegal_seen   (illegal_seen),
    .long_seen      (long_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) script.push_back(s[i]);
  endfunction

  // A trailing L on roughly a third of the well-formed literals.
  function automatic void add_suffix();
    if ($urandom_range(0, 2) == 0) script.push_back(CHAR_UPPER_L);
  endfunction

  function automatic logic [7:0] random_digit(input int top);
    return 8'(CHAR_ZERO + 8'($urandom_range(0, top)));
  endfunction

  // Appends one random token and its separator. Most tokens are well formed
  // with random content so that every state and long values are reached; the
  // rest are broken literals and plain noise bytes.
  function automatic void add_random_token();
    int    pick;
    int    n;
    string hex_set;
    hex_set = "0123456789abcdefABCDEF";
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // Decimal; the long ones can wrap past 32 bits.
      script.push_back(8'(CHAR_ZERO + 8'($urandom_range(1, 9))));
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 5);
      repeat (n) script.push_back(random_digit(9));
      add_suffix();
    end else if (pick < 40) begin
      script.push_back(CHAR_ZERO);
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 5);
      repeat (n) script.push_back(random_digit(7));
      add_suffix();
    end else if (pick < 60) begin
      script.push_back(CHAR_ZERO);
      script.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 5);
      repeat (n) script.push_back(hex_set[$urandom_range(0, 21)]);
      add_suffix();
    end else if (pick < 65) begin
      script.push_back(CHAR_ZERO);
    end else if (pick < 85) begin
      case ($urandom_range(0, 4))
        0: begin
          // Prefix with no hex digit after it.
          script.push_back(CHAR_ZERO);
          script.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
        end
        1: begin
          script.push_back(CHAR_ZERO);
          script.push_back(CHAR_UPPER_L);
        end
        2: begin
          // Something after the suffix.
          script.push_back(random_digit(9));
          script.push_back(CHAR_UPPER_L);
          script.push_back(hex_set[$urandom_range(0, 21)]);
        end
        3: begin
          script.push_back(CHAR_ZERO);
          script.push_back(8'(CHAR_ZERO + 8'($urandom_range(8, 9))));
        end
        default: begin
          script.push_back(random_digit(9));
          script.push_back(8'($urandom_range(0, 255)));
          script.push_back(random_digit(9));
        end
      endcase
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) script.push_back(8'($urandom_range(0, 255)));
    end
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
    repeat (n) script.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NEWLINE);
  endfunction

  // Sender: reset, then the character stream with random idle bursts.
  initial begin : sender
    bit idle_on;
    rst        <= 1'b1;
    char_valid <= 1'b0;
    char_byte  <= 8'h00;
    sent_count = 0;
    last_part  = 1'b0;
    idle_on    = 1'b1;

    // Directed text: lone zero, zero with suffix, lone prefix, a character
    // after the suffix, non-ASCII and NUL bytes in an illegal token, long
    // octal and hex literals, and repeated whitespace at the end.
    add_text("0 0L 0x\n7L1 ");
    script.push_back(8'hFF);
    script.push_back(8'h00);
    script.push_back(CHAR_SPACE);
    add_text("07L 0XfL\n ");
    while (script.size() < SCRIPT_LEN) add_random_token();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (sent_count % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
      last_part = (sent_count >= script.size() - QUIET_TAIL);
      if (!last_part && !hold_active && idle_on && $urandom_range(0, 3) == 0) begin
        char_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      char_valid <= 1'b1;
      char_byte  <= script[i];
      // The transaction completes at the first edge without a stall.
      @(posedge clk);
      while (char_stall) @(posedge clk);
      sent_count++;
    end
    char_valid <= 1'b0;

    // Let every due token drain, then a few more cycles to catch stray ones.
    while (pending_tokens != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters; %0d tokens checked, %0d illegal and %0d with suffix.",
             sent_count, tokens_checked, illegal_seen, long_seen);
    $display("Both sides idled at random, and the result side held off %0d cycles once.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_tokens == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: random stall bursts and quiet stretches, one long hold-off so
  // the output register fills and the lexer has to stall its input, and no
  // stalling at all in the last part of the run.
  initial begin : receiver
    int pick;
    int n;
    token_stall <= 1'b0;
    hold_active <= 1'b0;
    hold_done   = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && sent_count >= HOLD_AT) begin
        token_stall <= 1'b1;
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
        hold_done = 1'b1;
      end else if (last_part) begin
        token_stall <= 1'b0;
        @(posedge clk);
      end else begin
        pick = $urandom_range(0, 7);
        token_stall <= (pick < 2);
        n = (pick == 2) ? $urandom_range(20, 80) : $urandom_range(1, 9);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
